[src/bct_pkg.sv]
package bct_pkg;

  // Characters the scanner reacts to.
  localparam logic [20:0] CH_TAB   = 21'h00009;
  localparam logic [20:0] CH_SPACE = 21'h00020;
  localparam logic [20:0] CH_QUOTE = 21'h00022;
  localparam logic [20:0] CH_LPAR  = 21'h00028;
  localparam logic [20:0] CH_RPAR  = 21'h00029;
  localparam logic [20:0] CH_COMMA = 21'h0002C;
  localparam logic [20:0] CH_DOT   = 21'h0002E;
  localparam logic [20:0] CH_ZERO  = 21'h00030;
  localparam logic [20:0] CH_NINE  = 21'h00039;
  localparam logic [20:0] CH_UP_E  = 21'h00045;
  localparam logic [20:0] CH_LBRK  = 21'h0005B;
  localparam logic [20:0] CH_BSL   = 21'h0005C;
  localparam logic [20:0] CH_RBRK  = 21'h0005D;
  localparam logic [20:0] CH_LOW_E = 21'h00065;

  // Token types.
  localparam logic [3:0] TOK_IDENT  = 4'd0;
  localparam logic [3:0] TOK_NUMBER = 4'd1;
  localparam logic [3:0] TOK_STRING = 4'd2;
  localparam logic [3:0] TOK_LPAR   = 4'd3;
  localparam logic [3:0] TOK_RPAR   = 4'd4;
  localparam logic [3:0] TOK_LBRK   = 4'd5;
  localparam logic [3:0] TOK_RBRK   = 4'd6;
  localparam logic [3:0] TOK_QUOTE  = 4'd7;
  localparam logic [3:0] TOK_COMMA  = 4'd8;
  localparam logic [3:0] TOK_DOT    = 4'd9;

  // Error codes.
  localparam logic [2:0] ERR_UNEXPECTED = 3'd0;
  localparam logic [2:0] ERR_NO_CPAR    = 3'd1;
  localparam logic [2:0] ERR_NO_CBRK    = 3'd2;
  localparam logic [2:0] ERR_QUOTE      = 3'd3;
  localparam logic [2:0] ERR_NO_OPAR    = 3'd4;
  localparam logic [2:0] ERR_NO_OBRK    = 3'd5;
  localparam logic [2:0] ERR_OVERFLOW   = 3'd6;

  // Results per input beat and depth of the result queue.
  localparam int MAX_RES = 4;
  localparam int QDEPTH  = 8;

  typedef enum logic [1:0] {
    KIND_TOKEN = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic [5:0] {
    M_IDLE   = 6'b000001,
    M_IDENT  = 6'b000010,
    M_NUMBER = 6'b000100,
    M_DOT    = 6'b001000,
    M_STRING = 6'b010000,
    M_ESC    = 6'b100000
  } mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  ttype;
    logic [2:0]  err;
    logic [15:0] pos;
    logic [15:0] len;
    logic        last;
  } res_t;

  // All results caused by one input beat.
  typedef struct packed {
    logic [2:0]                cnt;
    res_t [MAX_RES-1:0]        res;
  } burst_t;

  function automatic logic is_digit(input logic [20:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_delim(input logic [20:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LPAR) || (c == CH_RPAR) ||
           (c == CH_LBRK) || (c == CH_RBRK) || (c == CH_QUOTE) || (c == CH_COMMA) ||
           (c == CH_DOT) || (c == CH_BSL);
  endfunction

  // Distance from a to b, zero when b is not past a.
  function automatic logic [15:0] span16(input logic [15:0] a, input logic [15:0] b);
    return (b > a) ? (b - a) : 16'd0;
  endfunction

  function automatic res_t mk_res(input kind_t k, input logic [3:0] t, input logic [2:0] e,
                                  input logic [15:0] p, input logic [15:0] l);
    res_t r;
    r.kind  = k;
    r.ttype = t;
    r.err   = e;
    r.pos   = p;
    r.len   = l;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

[src/bct_scan.sv]
module bct_scan import bct_pkg::*; #(
  parameter int          STACK_DEPTH = 32,
  parameter int unsigned MAX_LINE    = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [20:0] code_point,
  input  logic        line_end,
  output burst_t      burst
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [15:0] POS_CAP = (MAX_LINE < 32'd65535) ? 16'(MAX_LINE) : 16'hFFFF;

  mode_t       mode_r, mode_nxt;
  logic [15:0] ts_r, ts_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic [1:0]  rcnt_r, rcnt_nxt;
  logic        rdot_r, rdot_nxt;
  logic [15:0] cpos_r, cpos_nxt;
  logic        failed_r, failed_nxt;
  logic [CW-1:0] scnt_r, scnt_nxt;
  logic [STACK_DEPTH-1:0] stack_r, stack_nxt;

  res_t [MAX_RES-1:0] rs;
  logic [2:0]  nres;
  mode_t       cm;
  logic [15:0] cts;
  logic        go, do_idle;
  logic [15:0] p, rp1, rp2;
  logic [20:0] c;
  logic        is_e;

  assign c    = code_point;
  assign p    = cpos_r;
  assign rp1  = (p > 16'd1) ? (p - 16'd1) : 16'd1;
  assign rp2  = (p > 16'd2) ? (p - 16'd2) : 16'd1;
  assign is_e = (c == CH_LOW_E) || (c == CH_UP_E);

  // One character or one line end, processed in a single pass.
  always_comb begin
    mode_nxt   = mode_r;
    ts_nxt     = ts_r;
    flags_nxt  = flags_r;
    rcnt_nxt   = rcnt_r;
    rdot_nxt   = rdot_r;
    cpos_nxt   = cpos_r;
    failed_nxt = failed_r;
    scnt_nxt   = scnt_r;
    stack_nxt  = stack_r;
    rs         = '0;
    nres       = 3'd0;
    cm         = mode_r;
    cts        = ts_r;
    go         = 1'b0;
    do_idle    = 1'b0;
    if (fire && line_end) begin
      // Close any open token, check brackets, then report the line as done.
      if (!failed_r) begin
        unique case (mode_r)
          M_IDENT: begin
            rs[nres[1:0]] = mk_res(KIND_TOKEN, TOK_IDENT, ERR_UNEXPECTED, ts_r,
                                   span16(ts_r, p));
            nres = nres + 3'd1;
          end
          M_NUMBER: begin
            rs[nres[1:0]] = mk_res(KIND_TOKEN, TOK_NUMBER, ERR_UNEXPECTED, ts_r,
                                   span16(ts_r, p));
            nres = nres + 3'd1;
          end
          M_DOT: begin
            rs[nres[1:0]] = mk_res(KIND_TOKEN, TOK_DOT, ERR_UNEXPECTED, ts_r, 16'd1);
            nres = nres + 3'd1;
          end
          M_STRING, M_ESC: begin
            rs[nres[1:0]] = mk_res(KIND_TOKEN, TOK_STRING, ERR_UNEXPECTED, ts_r,
                                   span16(ts_r, p));
            nres = nres + 3'd1;
            rs[nres[1:0]] = mk_res(KIND_ERROR, TOK_IDENT, ERR_QUOTE, p, 16'd0);
            nres = nres + 3'd1;
          end
          default: ;
        endcase
        if ((mode_r != M_STRING) && (mode_r != M_ESC) && (scnt_r != '0)) begin
          rs[nres[1:0]] = mk_res(KIND_ERROR, TOK_IDENT,
                                 stack_r[0] ? ERR_NO_CBRK : ERR_NO_CPAR, p, 16'd0);
          nres = nres + 3'd1;
        end
      end
      rs[nres[1:0]] = mk_res(KIND_DONE, TOK_IDENT, ERR_UNEXPECTED, p, 16'd0);
      nres       = nres + 3'd1;
      mode_nxt   = M_IDLE;
      ts_nxt     = 16'd0;
      flags_nxt  = 2'd0;
      rcnt_nxt   = 2'd0;
      rdot_nxt   = 1'b0;
      cpos_nxt   = 16'd1;
      failed_nxt = 1'b0;
      scnt_nxt   = '0;
    end else if (fire) begin
      cpos_nxt = (p < POS_CAP) ? (p + 16'd1) : POS_CAP;
      if (!failed_r) begin
        if (mode_r == M_NUMBER) begin
          // Number body: digits, one point, one exponent letter.
          if (is_digit(c)) begin
            rcnt_nxt = 2'd0;
          end else if (c == CH_DOT) begin
            if (flags_r != 2'd0) begin
              rs[nres[1:0]] = mk_res(KIND_ERROR, TOK_IDENT, ERR_UNEXPECTED, p, 16'd0);
              nres       = nres + 3'd1;
              failed_nxt = 1'b1;
              mode_nxt   = M_IDLE;
            end else begin
              flags_nxt = flags_r | 2'b01;
              if (rcnt_r == 2'd0) rdot_nxt = 1'b1;
              rcnt_nxt = rcnt_r + 2'd1;
            end
          end else if (is_e && !flags_r[1]) begin
            flags_nxt = flags_r | 2'b10;
            if (rcnt_r == 2'd0) rdot_nxt = 1'b0;
            rcnt_nxt = rcnt_r + 2'd1;
          end else begin
            // Number ends at its last digit; the trailing point or exponent
            // letter is scanned again ahead of this character.
            rs[nres[1:0]] = mk_res(KIND_TOKEN, TOK_NUMBER, ERR_UNEXPECTED, ts_r,
                                   span16({14'd0, rcnt_r}, span16(ts_r, p)));
            nres     = nres + 3'd1;
            rcnt_nxt = 2'd0;
            go       = 1'b1;
            unique case (rcnt_r)
              2'd1: begin
                cm  = rdot_r ? M_DOT : M_IDENT;
                cts = rp1;
              end
              2'd2: begin
                rs[nres[1:0]] = mk_res(KIND_TOKEN, TOK_DOT, ERR_UNEXPECTED, rp2, 16'd1);
                nres = nres + 3'd1;
                cm   = M_IDENT;
                cts  = rp1;
              end
              default: cm = M_IDLE;
            endcase
          end
        end else begin
          go = 1'b1;
        end
      end
      if (go) begin
        mode_nxt = cm;
        ts_nxt   = cts;
        unique case (cm)
          M_IDENT: begin
            if (is_delim(c)) begin
              rs[nres[1:0]] = mk_res(KIND_TOKEN, TOK_IDENT, ERR_UNEXPECTED, cts,
                                     span16(cts, p));
              nres    = nres + 3'd1;
              do_idle = 1'b1;
            end
          end
          M_DOT: begin
            if (is_digit(c)) begin
              flags_nxt = 2'b01;
              rcnt_nxt  = 2'd0;
              mode_nxt  = M_NUMBER;
            end else begin
              rs[nres[1:0]] = mk_res(KIND_TOKEN, TOK_DOT, ERR_UNEXPECTED, cts, 16'd1);
              nres    = nres + 3'd1;
              do_idle = 1'b1;
            end
          end
          M_STRING: begin
            if (c == CH_QUOTE) begin
              rs[nres[1:0]] = mk_res(KIND_TOKEN, TOK_STRING, ERR_UNEXPECTED, cts,
                                     span16(cts, p));
              nres = nres + 3'd1;
              rs[nres[1:0]] = mk_res(KIND_TOKEN, TOK_QUOTE, ERR_UNEXPECTED, p, 16'd1);
              nres     = nres + 3'd1;
              mode_nxt = M_IDLE;
            end else if (c == CH_BSL) begin
              mode_nxt = M_ESC;
            end
          end
          M_ESC:   mode_nxt = M_STRING;
          default: do_idle = 1'b1;
        endcase
      end
      // A character seen between tokens.
      if (do_idle) begin
        mode_nxt = M_IDLE;
        if ((c == CH_LPAR) || (c == CH_LBRK)) begin
          if (scnt_r >= CW'(STACK_DEPTH)) begin
            rs[nres[1:0]] = mk_res(KIND_ERROR, TOK_IDENT, ERR_OVERFLOW, p, 16'd0);
            nres       = nres + 3'd1;
            failed_nxt = 1'b1;
          end else begin
            stack_nxt = {stack_r[STACK_DEPTH-2:0], (c == CH_LBRK)};
            scnt_nxt  = scnt_r + CW'(1);
            rs[nres[1:0]] = mk_res(KIND_TOKEN, (c == CH_LBRK) ? TOK_LBRK : TOK_LPAR,
                                   ERR_UNEXPECTED, p, 16'd1);
            nres = nres + 3'd1;
          end
        end else if ((c == CH_RPAR) || (c == CH_RBRK)) begin
          if ((scnt_r != '0) && (stack_r[0] == (c == CH_RBRK))) begin
            stack_nxt = {1'b0, stack_r[STACK_DEPTH-1:1]};
            scnt_nxt  = scnt_r - CW'(1);
            rs[nres[1:0]] = mk_res(KIND_TOKEN, (c == CH_RBRK) ? TOK_RBRK : TOK_RPAR,
                                   ERR_UNEXPECTED, p, 16'd1);
            nres = nres + 3'd1;
          end else begin
            rs[nres[1:0]] = mk_res(KIND_ERROR, TOK_IDENT,
                                   (c == CH_RBRK) ? ERR_NO_OBRK : ERR_NO_OPAR, p, 16'd0);
            nres       = nres + 3'd1;
            failed_nxt = 1'b1;
          end
        end else if (c == CH_QUOTE) begin
          rs[nres[1:0]] = mk_res(KIND_TOKEN, TOK_QUOTE, ERR_UNEXPECTED, p, 16'd1);
          nres     = nres + 3'd1;
          ts_nxt   = (p < POS_CAP) ? (p + 16'd1) : p;
          mode_nxt = M_STRING;
        end else if (c == CH_COMMA) begin
          rs[nres[1:0]] = mk_res(KIND_TOKEN, TOK_COMMA, ERR_UNEXPECTED, p, 16'd1);
          nres = nres + 3'd1;
        end else if (c == CH_DOT) begin
          ts_nxt   = p;
          mode_nxt = M_DOT;
        end else if (is_digit(c)) begin
          ts_nxt    = p;
          flags_nxt = 2'd0;
          rcnt_nxt  = 2'd0;
          mode_nxt  = M_NUMBER;
        end else if (c == CH_BSL) begin
          rs[nres[1:0]] = mk_res(KIND_ERROR, TOK_IDENT, ERR_UNEXPECTED, p, 16'd0);
          nres       = nres + 3'd1;
          failed_nxt = 1'b1;
        end else if ((c != CH_SPACE) && (c != CH_TAB)) begin
          ts_nxt   = p;
          mode_nxt = M_IDENT;
        end
      end
    end
    if (nres != 3'd0) rs[nres[1:0] - 2'd1].last = 1'b1;
  end

  assign burst = {nres, rs};

  // Scanner state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      ts_r     <= 16'd0;
      flags_r  <= 2'd0;
      rcnt_r   <= 2'd0;
      rdot_r   <= 1'b0;
      cpos_r   <= 16'd1;
      failed_r <= 1'b0;
      scnt_r   <= '0;
    end else begin
      mode_r   <= mode_nxt;
      ts_r     <= ts_nxt;
      flags_r  <= flags_nxt;
      rcnt_r   <= rcnt_nxt;
      rdot_r   <= rdot_nxt;
      cpos_r   <= cpos_nxt;
      failed_r <= failed_nxt;
      scnt_r   <= scnt_nxt;
    end
  end

  // Bracket stack contents; the top sits in bit 0.
  always_ff @(posedge clk) begin
    stack_r <= stack_nxt;
  end

  // A failed line stays between tokens until its end.
  a_failed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> (mode_r == M_IDLE))
    else $error("failed line left the idle mode");

  // The bracket count never passes the stack depth.
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scnt_r <= CW'(STACK_DEPTH))
    else $error("bracket count beyond stack depth");

  // A line end always answers, and the line starts over afterwards.
  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && line_end) |-> (burst.cnt != 3'd0) ##1 (cpos_r == 16'd1 && scnt_r == '0))
    else $error("line end handled wrongly");

endmodule

[src/bct_res_fifo.sv]
module bct_res_fifo import bct_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  burst_t burst,
  output logic   room,
  output logic   head_valid,
  input  logic   head_ready,
  output res_t   head
);

  localparam int PW = $clog2(QDEPTH);

  res_t [QDEPTH-1:0] mem_r;
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r;
  logic          pop;
  logic [2:0]    nin;

  assign nin        = push ? burst.cnt : 3'd0;
  assign pop        = head_valid && head_ready;
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];
  assign room       = (cnt_r <= (PW+1)'(QDEPTH - MAX_RES));

  // Write up to a full burst of results at consecutive slots.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (3'(i) < nin) mem_r[wr_r + PW'(i)] <= burst.res[i];
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PW'(nin);
      rd_r  <= rd_r + PW'(pop);
      cnt_r <= cnt_r + (PW+1)'(nin) - (PW+1)'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(QDEPTH))
    else $error("result queue overfilled");

endmodule

[src/bracket_checking_tokenizer.sv]
// Channel  Dir  Beat contents
// in_      in   tdata[20:0] code_point, tlast line_end
// out_     out  tdata token_type/error_code/position/token_length, tuser result_kind,
//               tlast last_of_run
// A character is scanned in the cycle it is accepted; its results enter an
// eight-entry queue and leave one per cycle while out_tready is high.
// One beat is accepted per cycle while the queue has room for four results; the
// output port drains one result per cycle when not stalled, which sets the sustained rate.
// Reset is synchronous and active low; it empties the queue and starts a new line.
// A stalled output keeps its beat and fills the queue, then in_tready drops.
module bracket_checking_tokenizer import bct_pkg::*; #(
  parameter int          STACK_DEPTH = 32,
  parameter int unsigned MAX_LINE    = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [20:0] code_point, rest zero
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] token_type, [6:4] error_code,
                                  // [22:7] position, [38:23] token_length
  output logic [1:0]  out_tuser,  // [1:0] result_kind
  output logic        out_tlast
);

  logic   fire;
  burst_t burst;
  res_t   head;

  assign fire = in_tvalid && in_tready;

  bct_scan #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_LINE    (MAX_LINE)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .code_point (in_tdata[20:0]),
    .line_end   (in_tlast),
    .burst      (burst)
  );

  bct_res_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .burst      (burst),
    .room       (in_tready),
    .head_valid (out_tvalid),
    .head_ready (out_tready),
    .head       (head)
  );

  // Pack the head result onto the output beat.
  assign out_tdata = {1'b0, head.len, head.pos, head.err, head.ttype};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule
